/* sv/dsr_pkg.sv */
// Shared types for the descending record sorter: record layout, FSM states, control structs.
package dsr_pkg;

  // Field widths of one record
  localparam int unsigned TagW   = 6;
  localparam int unsigned CountW = 32;
  localparam int unsigned TimeW  = 48;

  // One stored record
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  average;
    logic [TimeW-1:0]  maximum;
  } record_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_PLACE,
    ST_EMIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the incoming record
    logic rd_shift;  // read the entry just above the insertion point
    logic shift;     // move the read entry one place down
    logic place;     // write the new record at the insertion point
    logic emit_rd;   // read the next entry for output
    logic clear;     // empty the store after emission
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;       // store holds the maximum number of records
    logic empty;      // store holds no record
    logic key_less;   // read entry has a smaller key than the new record
    logic at_one;     // insertion point is entry one
    logic final_rec;  // captured record closes the set
    logic emit_last;  // entry being read for output is the last one
  } dp_sts_t;

endpackage

/* sv/dsr_datapath.sv */
// Datapath: record memory, insertion pointer, fill level and output read register.
module dsr_datapath import dsr_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [TagW-1:0]   record_tag_i,
  input  logic [CountW-1:0] hit_count_i,
  input  logic [TimeW-1:0]  average_time_i,
  input  logic [TimeW-1:0]  maximum_time_i,
  input  logic              final_record_i,
  output record_t           rd_data_o
);

  localparam int unsigned AddrW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned FillW = $clog2(MAX_RECORDS + 1);

  record_t            mem [MAX_RECORDS];
  record_t            rd_data_q;
  record_t            new_q;
  logic               final_q;
  logic [FillW-1:0]   fill_q;
  logic [AddrW-1:0]   ins_q;
  logic [AddrW-1:0]   emit_q;
  logic [AddrW-1:0]   rd_addr;

  // Captured record and its last flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_q.tag     <= record_tag_i;
      new_q.count   <= hit_count_i;
      new_q.average <= average_time_i;
      new_q.maximum <= maximum_time_i;
      final_q       <= final_record_i;
    end
  end

  // Fill level, insertion pointer and emit pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ins_q  <= '0;
      emit_q <= '0;
    end else begin
      if (cmd_i.load && (fill_q != FillW'(MAX_RECORDS))) begin
        ins_q <= fill_q[AddrW-1:0];
      end else if (cmd_i.shift) begin
        ins_q <= ins_q - AddrW'(1);
      end
      if (cmd_i.clear) begin
        fill_q <= '0;
        emit_q <= '0;
      end else begin
        if (cmd_i.place) fill_q <= fill_q + FillW'(1);
        if (cmd_i.emit_rd) emit_q <= emit_q + AddrW'(1);
      end
    end
  end

  // Single read address: entry above the insertion point while inserting, else emit pointer
  assign rd_addr = cmd_i.rd_shift ? (ins_q - AddrW'(1)) : emit_q;

  // Record memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      mem[ins_q] <= rd_data_q;
    end else if (cmd_i.place) begin
      mem[ins_q] <= new_q;
    end
    if (cmd_i.rd_shift || cmd_i.emit_rd) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o.full      = (fill_q == FillW'(MAX_RECORDS));
    sts_o.empty     = (fill_q == '0);
    sts_o.key_less  = (rd_data_q.average < new_q.average);
    sts_o.at_one    = (ins_q == AddrW'(1));
    sts_o.final_rec = final_q;
    sts_o.emit_last = (FillW'(emit_q) == (fill_q - FillW'(1)));
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/dsr_ctrl.sv */
// Controller: sequences insertion of each record and the drain of a sorted set.
module dsr_ctrl import dsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    final_flag_i,
  output logic    busy_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i,
  output logic    result_valid_o,
  output logic    out_last_o
);

  state_e state_q, state_d;
  logic   strobe_q, strobe_d;
  logic   last_q, last_d;

  // State and result strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    busy_o   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.full) begin
            // record dropped; a final one still drains the set
            state_d = ST_IDLE;
            if (final_flag_i) state_d = ST_EMIT;
          end else if (sts_i.empty) begin
            state_d = ST_PLACE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_shift = 1'b1;
        state_d        = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (sts_i.key_less) begin
          cmd_o.shift = 1'b1;
          state_d     = sts_i.at_one ? ST_PLACE : ST_READ;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = sts_i.final_rec ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd_o.emit_rd = 1'b1;
        strobe_d      = 1'b1;
        last_d        = sts_i.emit_last;
        if (sts_i.emit_last) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_valid_o = strobe_q;
  assign out_last_o     = last_q;

endmodule

/* sv/descending_record_sorter_unit.sv */
// Top level of the descending record sorter: controller plus datapath.
//
// Records arrive one per transaction (start_i high while busy_o is low) and are kept in a
// memory that is always in descending order of average time; equal keys keep load order.
// Inserting a record walks up from the end of the stored set: each stored record with a
// smaller key is read, compared and moved down one place, and the walk stops at a record
// with an equal or larger key or at entry zero; the new record is then written at the
// insertion point. At most MAX_RECORDS-1 stored records move for one record, none when
// the store is empty. busy_o stays high until the record is placed. The record memory has
// a single read address, so the walk reads and compares the stored records, one at a time,
// from the end down. A record that arrives while MAX_RECORDS records are stored is dropped in
// its accepting cycle. When a record flagged final has been placed (or dropped), the set is
// emitted one result per cycle, largest key first, each result on the out ports for one
// cycle with result_valid_o high; out_last_o marks the last one. The receiver cannot hold
// results off. busy_o stays high until the last read has been issued, after which the
// store is empty and a new set may start.
module descending_record_sorter_unit import dsr_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [TagW-1:0]   record_tag_i,
  input  logic [CountW-1:0] hit_count_i,
  input  logic [TimeW-1:0]  average_time_i,
  input  logic [TimeW-1:0]  maximum_time_i,
  input  logic              final_record_i,
  output logic              result_valid_o,
  output logic [TagW-1:0]   out_tag_o,
  output logic [CountW-1:0] out_count_o,
  output logic [TimeW-1:0]  out_average_o,
  output logic [TimeW-1:0]  out_maximum_o,
  output logic              out_last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  record_t rd_data;

  // Sequencing
  dsr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .final_flag_i   (final_record_i),
    .busy_o         (busy_o),
    .cmd_o          (cmd),
    .sts_i          (sts),
    .result_valid_o (result_valid_o),
    .out_last_o     (out_last_o)
  );

  // Storage and compare
  dsr_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .record_tag_i   (record_tag_i),
    .hit_count_i    (hit_count_i),
    .average_time_i (average_time_i),
    .maximum_time_i (maximum_time_i),
    .final_record_i (final_record_i),
    .rd_data_o      (rd_data)
  );

  // Result ports straight from the memory read register
  assign out_tag_o     = rd_data.tag;
  assign out_count_o   = rd_data.count;
  assign out_average_o = rd_data.average;
  assign out_maximum_o = rd_data.maximum;

endmodule

/* test/descending_record_sorter_unit_tb.sv */
// Testbench for the descending record sorter: directed and randomised record sets checked against a predictor.
`timescale 1ns / 1ps

module descending_record_sorter_unit_tb;
  import dsr_pkg::*;

  localparam int unsigned MaxRecords = 64;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // One record waiting to be driven, with the idle gap that follows it
  typedef struct {
    record_t     rec;
    logic        last;
    int unsigned gap;
  } pending_rec_t;

  // One record as it should leave the block
  typedef struct packed {
    record_t rec;
    logic    last;
  } sorted_entry_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [TagW-1:0]   record_tag_i = '0;
  logic [CountW-1:0] hit_count_i = '0;
  logic [TimeW-1:0]  average_time_i = '0;
  logic [TimeW-1:0]  maximum_time_i = '0;
  logic              final_record_i = 1'b0;
  logic              result_valid_o;
  logic [TagW-1:0]   out_tag_o;
  logic [CountW-1:0] out_count_o;
  logic [TimeW-1:0]  out_average_o;
  logic [TimeW-1:0]  out_maximum_o;
  logic              out_last_o;

  pending_rec_t  record_feed_q[$];
  sorted_entry_t sorted_out_q[$];
  pending_rec_t  driven_rec;
  pending_rec_t  next_rec;
  sorted_entry_t want;
  record_t       sorted_rec[MaxRecords];
  int unsigned   stored_cnt = 0;
  int unsigned   gap_left = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   fail_cnt = 0;
  bit            taken = 1'b0;

  descending_record_sorter_unit #(
    .MAX_RECORDS(MaxRecords)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .record_tag_i  (record_tag_i),
    .hit_count_i   (hit_count_i),
    .average_time_i(average_time_i),
    .maximum_time_i(maximum_time_i),
    .final_record_i(final_record_i),
    .result_valid_o(result_valid_o),
    .out_tag_o     (out_tag_o),
    .out_count_o   (out_count_o),
    .out_average_o (out_average_o),
    .out_maximum_o (out_maximum_o),
    .out_last_o    (out_last_o)
  );

  always #10 clk_i = ~clk_i;

  // Stable descending insertion; a final record flushes the whole set
  task automatic insert_sorted(input pending_rec_t it);
    int unsigned pos;
    int unsigned k;
    sorted_entry_t ent;
    if (stored_cnt < MaxRecords) begin
      pos = 0;
      while (pos < stored_cnt && sorted_rec[pos].average >= it.rec.average) pos++;
      for (k = stored_cnt; k > pos; k--) sorted_rec[k] = sorted_rec[k-1];
      sorted_rec[pos] = it.rec;
      stored_cnt++;
    end
    if (it.last) begin
      for (k = 0; k < stored_cnt; k++) begin
        ent.rec = sorted_rec[k];
        ent.last = (k + 1 == stored_cnt);
        sorted_out_q.push_back(ent);
      end
      stored_cnt = 0;
    end
  endtask

  task automatic queue_record(input logic [TagW-1:0] tag, input logic [CountW-1:0] cnt,
                              input logic [TimeW-1:0] avg, input logic [TimeW-1:0] mx,
                              input logic last, input int unsigned gap);
    pending_rec_t it;
    it.rec.tag = tag;
    it.rec.count = cnt;
    it.rec.average = avg;
    it.rec.maximum = mx;
    it.last = last;
    it.gap = gap;
    record_feed_q.push_back(it);
  endtask

  // Keys mix a narrow pool (plenty of ties), the extremes and full-width values
  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(0, 3))
      0: rand_time = TimeW'($urandom_range(0, 7));
      1: rand_time = $urandom_range(0, 1) ? TimeMax : '0;
      default: rand_time = TimeW'({$urandom(), $urandom()});
    endcase
  endfunction

  // Mostly back-to-back, sometimes short gaps, now and then a long one
  function automatic int unsigned rand_gap(input bit no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) rand_gap = 0;
    else if (r < 90) rand_gap = $urandom_range(1, 3);
    else rand_gap = $urandom_range(8, 40);
  endfunction

  task automatic queue_random_set(input int unsigned n_rec);
    int unsigned k;
    bit no_idle;
    no_idle = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n_rec; k++)
      queue_record(TagW'($urandom()), $urandom(), rand_time(), rand_time(),
                   k + 1 == n_rec, rand_gap(no_idle));
  endtask

  // Driver: present the next record once the previous transaction has gone through
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (record_feed_q.size() > 0) begin
        next_rec = record_feed_q.pop_front();
        driven_rec = next_rec;
        record_tag_i <= next_rec.rec.tag;
        hit_count_i <= next_rec.rec.count;
        average_time_i <= next_rec.rec.average;
        maximum_time_i <= next_rec.rec.maximum;
        final_record_i <= next_rec.last;
        gap_left <= next_rec.gap;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted records, check each result, watch for a hang
  always @(posedge clk_i) begin
    taken = rst_ni && start_i && !busy_o;
    if (taken) insert_sorted(driven_rec);
    if (rst_ni && result_valid_o) begin
      if (sorted_out_q.size() == 0) begin
        $display("%0t: unexpected result tag=%0d count=%h avg=%h max=%h last=%b", $time,
                 out_tag_o, out_count_o, out_average_o, out_maximum_o, out_last_o);
        fail_cnt++;
      end else begin
        want = sorted_out_q.pop_front();
        if (out_tag_o !== want.rec.tag || out_count_o !== want.rec.count ||
            out_average_o !== want.rec.average || out_maximum_o !== want.rec.maximum ||
            out_last_o !== want.last) begin
          $display("%0t: expected tag=%0d count=%h avg=%h max=%h last=%b", $time,
                   want.rec.tag, want.rec.count, want.rec.average, want.rec.maximum,
                   want.last);
          $display("%0t:   actual tag=%0d count=%h avg=%h max=%h last=%b", $time,
                   out_tag_o, out_count_o, out_average_o, out_maximum_o, out_last_o);
          fail_cnt++;
        end
      end
    end
    if (taken || (rst_ni && result_valid_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned n_random;
    int unsigned set_idx;
    int unsigned set_len;
    int unsigned k;

    // Single-record sets at both extremes
    queue_record('1, CountMax, TimeMax, TimeMax, 1'b1, 0);
    queue_record('0, '0, '0, '0, 1'b1, 0);
    // Ties keep load order; extremes of the key mixed in
    queue_record(6'd1, 32'd100, 48'd10, 48'd20, 1'b0, 0);
    queue_record(6'd2, 32'd200, 48'd10, 48'd30, 1'b0, 0);
    queue_record(6'd3, 32'd300, TimeMax, TimeMax, 1'b0, 1);
    queue_record(6'd4, 32'd400, '0, 48'd1, 1'b0, 0);
    queue_record(6'd5, 32'd500, 48'd10, 48'd10, 1'b0, 2);
    queue_record(6'd6, 32'd600, TimeMax, 48'd7, 1'b0, 0);
    queue_record(6'd7, 32'd700, 48'd5, 48'd9, 1'b1, 0);
    // Ascending keys: every record moves all the stored ones down
    for (k = 1; k <= 5; k++)
      queue_record(TagW'(k + 8), CountW'(k), TimeW'(k), TimeW'(k * 3), k == 5, 0);
    // Already descending: nothing has to move
    for (k = 3; k >= 1; k--)
      queue_record(TagW'(k + 16), CountW'(k), TimeW'(k), TimeW'(k), k == 1, 0);
    // Alternating bit patterns on every field
    queue_record(6'h2A, 32'hAAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, 0);
    queue_record(6'h15, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b1, 0);

    // Random sets, mostly small; one overfills the store and ends on a dropped final
    n_random = 0;
    set_idx = 0;
    while (n_random < 90) begin
      if (set_idx == 2) begin
        queue_random_set(MaxRecords + 3);
        n_random += MaxRecords + 3;
      end else begin
        set_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
        queue_random_set(set_len);
        n_random += set_len;
      end
      set_idx++;
    end

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Checked at the rising edge, where the driven inputs are settled
    do @(posedge clk_i);
    while (record_feed_q.size() > 0 || start_i || sorted_out_q.size() > 0);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_cnt == 0 && sorted_out_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/dsr_pkg.sv
sv/dsr_datapath.sv
sv/dsr_ctrl.sv
sv/descending_record_sorter_unit.sv
test/descending_record_sorter_unit_tb.sv
